[hdl/extlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extlc_pkg - shared types and constants for the exclusive two-level cache
// Geometry of the L2 (near) and L3 (far) stores, row layouts, outcome codes.
// ----------------------------------------------------------------------------
package extlc_pkg;

  localparam int NEAR_SETS   = 1024;
  localparam int NEAR_WAYS   = 8;
  localparam int FAR_SETS    = 2048;
  localparam int FAR_WAYS    = 16;
  localparam int OFFSET_BITS = 6;

  localparam int ADDR_W  = 64;
  localparam int BLOCK_W = ADDR_W - OFFSET_BITS;
  localparam int NSET_W  = $clog2(NEAR_SETS);
  localparam int NTAG_W  = BLOCK_W - NSET_W;
  localparam int NWAY_W  = $clog2(NEAR_WAYS);
  localparam int FSET_W  = $clog2(FAR_SETS);
  localparam int FTAG_W  = BLOCK_W - FSET_W;
  localparam int FWAY_W  = $clog2(FAR_WAYS);

  localparam int CLR_SETS = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
  localparam int CLR_W    = $clog2(CLR_SETS);

  typedef enum logic [1:0] {
    OUT_L2_HIT = 2'd0,
    OUT_L3_HIT = 2'd1,
    OUT_MISS   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [NTAG_W-1:0] tag;
    logic              valid;
    logic [NWAY_W-1:0] age;
  } near_line_t;

  typedef near_line_t [NEAR_WAYS-1:0] near_row_t;

  typedef struct packed {
    logic [FTAG_W-1:0] tag;
    logic              valid;
  } far_line_t;

  typedef far_line_t [FAR_WAYS-1:0] far_row_t;

  typedef struct packed {
    logic              hit;
    logic              full;
    logic [NTAG_W-1:0] vic_tag;
  } near_stat_t;

endpackage

[hdl/exclusive_two_level_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusive_two_level_cache - exclusive L2/L3 tag cache with LRU in L2
// Looks up one byte address per access and reports outcome and L2 victim.
// ----------------------------------------------------------------------------
// After reset the block sweeps both set stores, one row per cycle, and holds
// busy high until the sweep is done. An access is taken when start is high
// and busy is low; its result appears on the result ports for exactly one
// cycle with done_o high and must be captured then, since the receiver cannot
// stall. An access first passes through a lookup state that checks both set
// stores and writes back the L2 row. When an L2 line is evicted, a victim
// state then puts the victim in a free way of its own L3 set, or reports it
// dropped; when an L3 hit must also free its way in a different L3 set, a
// further state does so while busy stays high.
// ----------------------------------------------------------------------------
module exclusive_two_level_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [extlc_pkg::ADDR_W-1:0]   access_address_i,
  output logic                           done_o,
  output logic [1:0]                     outcome_o,
  output logic                           victim_valid_o,
  output logic [extlc_pkg::BLOCK_W-1:0]  victim_block_o,
  output logic                           victim_dropped_o
);
  import extlc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_VIC   = 3'd3;
  localparam logic [2:0] ST_FCLR  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CLR_W-1:0]   clr_q, clr_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic               fhit_q, fhit_d;
  logic [FWAY_W-1:0]  fway_q, fway_d;
  far_row_t           frow_q, frow_d;
  logic [BLOCK_W-1:0] vb_q, vb_d;

  logic               done_q, done_d;
  logic [1:0]         outcome_q, outcome_d;
  logic               vvalid_q, vvalid_d;
  logic [BLOCK_W-1:0] vblock_q, vblock_d;
  logic               vdrop_q, vdrop_d;

  logic [BLOCK_W-1:0] block;
  logic [NSET_W-1:0]  nset;
  logic [FSET_W-1:0]  fset;
  logic [FTAG_W-1:0]  ftag;
  logic [BLOCK_W-1:0] in_block;
  logic [BLOCK_W-1:0] look_vb;

  logic               near_we;
  logic [NSET_W-1:0]  near_waddr;
  near_row_t          near_wdata;
  logic [NSET_W-1:0]  near_raddr;
  near_row_t          near_rdata;
  near_row_t          near_new;
  near_stat_t         near_stat;

  logic               far_we;
  logic [FSET_W-1:0]  far_waddr;
  far_row_t           far_wdata;
  logic [FSET_W-1:0]  far_raddr;
  far_row_t           far_rdata;

  logic               look_fhit;
  logic [FWAY_W-1:0]  look_fway;
  logic               vic_free;
  logic [FWAY_W-1:0]  vic_fway;

  assign block    = addr_q[ADDR_W-1:OFFSET_BITS];
  assign nset     = block[NSET_W-1:0];
  assign fset     = block[FSET_W-1:0];
  assign ftag     = block[BLOCK_W-1:FSET_W];
  assign in_block = access_address_i[ADDR_W-1:OFFSET_BITS];
  assign look_vb  = {near_stat.vic_tag, nset};

  extlc_near_ram u_near_ram (
    .clk_i   (clk_i),
    .we_i    (near_we),
    .waddr_i (near_waddr),
    .wdata_i (near_wdata),
    .raddr_i (near_raddr),
    .rdata_o (near_rdata)
  );

  extlc_far_ram u_far_ram (
    .clk_i   (clk_i),
    .we_i    (far_we),
    .waddr_i (far_waddr),
    .wdata_i (far_wdata),
    .raddr_i (far_raddr),
    .rdata_o (far_rdata)
  );

  extlc_near_upd u_near_upd (
    .row_i  (near_rdata),
    .tag_i  (block[BLOCK_W-1:NSET_W]),
    .row_o  (near_new),
    .stat_o (near_stat)
  );

  // L3 lookup of the accessed block and free-way search in the victim's set
  always_comb begin
    look_fhit = 1'b0;
    look_fway = '0;
    vic_free  = 1'b0;
    vic_fway  = '0;
    for (int f = 0; f < FAR_WAYS; f++) begin
      if (!look_fhit && far_rdata[f].valid && far_rdata[f].tag == ftag) begin
        look_fhit = 1'b1;
        look_fway = FWAY_W'(f);
      end
      if (!vic_free && !far_rdata[f].valid) begin
        vic_free = 1'b1;
        vic_fway = FWAY_W'(f);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    addr_d    = addr_q;
    fhit_d    = fhit_q;
    fway_d    = fway_q;
    frow_d    = frow_q;
    vb_d      = vb_q;
    done_d    = 1'b0;
    outcome_d = outcome_q;
    vvalid_d  = vvalid_q;
    vblock_d  = vblock_q;
    vdrop_d   = vdrop_q;

    near_we    = 1'b0;
    near_waddr = nset;
    near_wdata = near_new;
    near_raddr = nset;
    far_we     = 1'b0;
    far_waddr  = fset;
    far_wdata  = far_rdata;
    far_raddr  = fset;

    unique case (state_q)
      ST_CLEAR: begin
        near_we    = (32'(clr_q) < NEAR_SETS);
        near_waddr = clr_q[NSET_W-1:0];
        near_wdata = '0;
        far_we     = (32'(clr_q) < FAR_SETS);
        far_waddr  = clr_q[FSET_W-1:0];
        far_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (32'(clr_q) == CLR_SETS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        near_raddr = in_block[NSET_W-1:0];
        far_raddr  = in_block[FSET_W-1:0];
        if (start) begin
          addr_d  = access_address_i;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        near_we  = 1'b1;
        vvalid_d = 1'b0;
        vblock_d = '0;
        vdrop_d  = 1'b0;
        if (near_stat.hit) begin
          outcome_d = OUT_L2_HIT;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          outcome_d = look_fhit ? OUT_L3_HIT : OUT_MISS;
          if (near_stat.full) begin
            // victim goes to its own L3 set before the hit way is freed
            fhit_d    = look_fhit;
            fway_d    = look_fway;
            frow_d    = far_rdata;
            vb_d      = look_vb;
            far_raddr = look_vb[FSET_W-1:0];
            state_d   = ST_VIC;
          end else begin
            far_we                    = look_fhit;
            far_wdata[look_fway].valid = 1'b0;
            done_d                    = 1'b1;
            state_d                   = ST_IDLE;
          end
        end
      end
      ST_VIC: begin
        far_we    = 1'b1;
        far_waddr = vb_q[FSET_W-1:0];
        if (vic_free) begin
          far_wdata[vic_fway].valid = 1'b1;
          far_wdata[vic_fway].tag   = vb_q[BLOCK_W-1:FSET_W];
        end
        vvalid_d = 1'b1;
        vblock_d = vb_q;
        vdrop_d  = !vic_free;
        done_d   = 1'b1;
        state_d  = ST_IDLE;
        if (fhit_q) begin
          if (vb_q[FSET_W-1:0] == fset) begin
            far_wdata[fway_q].valid = 1'b0;
          end else begin
            state_d = ST_FCLR;
          end
        end
      end
      ST_FCLR: begin
        far_we                 = 1'b1;
        far_waddr              = fset;
        far_wdata              = frow_q;
        far_wdata[fway_q].valid = 1'b0;
        state_d                = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    fhit_q    <= fhit_d;
    fway_q    <= fway_d;
    frow_q    <= frow_d;
    vb_q      <= vb_d;
    outcome_q <= outcome_d;
    vvalid_q  <= vvalid_d;
    vblock_q  <= vblock_d;
    vdrop_q   <= vdrop_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign outcome_o        = outcome_q;
  assign victim_valid_o   = vvalid_q;
  assign victim_block_o   = vblock_q;
  assign victim_dropped_o = vdrop_q;

endmodule

[hdl/extlc_near_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extlc_near_ram - L2 set store
// One row per set holds tag, valid and LRU rank of every way. One write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module extlc_near_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [extlc_pkg::NSET_W-1:0]  waddr_i,
  input  extlc_pkg::near_row_t          wdata_i,
  input  logic [extlc_pkg::NSET_W-1:0]  raddr_i,
  output extlc_pkg::near_row_t          rdata_o
);
  import extlc_pkg::*;

  near_row_t mem [NEAR_SETS];
  near_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/extlc_far_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extlc_far_ram - L3 set store
// One row per set holds tag and valid of every way. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module extlc_far_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [extlc_pkg::FSET_W-1:0]  waddr_i,
  input  extlc_pkg::far_row_t           wdata_i,
  input  logic [extlc_pkg::FSET_W-1:0]  raddr_i,
  output extlc_pkg::far_row_t           rdata_o
);
  import extlc_pkg::*;

  far_row_t mem [FAR_SETS];
  far_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/extlc_near_upd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extlc_near_upd - L2 row update
// Looks up a tag in one L2 row and builds the row to write back: touch on a
// hit, fill the lowest free way, or replace the LRU way.
// ----------------------------------------------------------------------------
module extlc_near_upd (
  input  extlc_pkg::near_row_t          row_i,
  input  logic [extlc_pkg::NTAG_W-1:0]  tag_i,
  output extlc_pkg::near_row_t          row_o,
  output extlc_pkg::near_stat_t         stat_o
);
  import extlc_pkg::*;

  always_comb begin
    logic              hit;
    logic              has_free;
    logic [NWAY_W-1:0] hit_way;
    logic [NWAY_W-1:0] free_way;
    logic [NWAY_W-1:0] vic_way;
    logic [NWAY_W-1:0] sel;
    logic              was_valid;
    logic [NWAY_W-1:0] old_age;

    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    vic_way  = '0;
    for (int w = 0; w < NEAR_WAYS; w++) begin
      if (!hit && row_i[w].valid && row_i[w].tag == tag_i) begin
        hit     = 1'b1;
        hit_way = NWAY_W'(w);
      end
      if (!has_free && !row_i[w].valid) begin
        has_free = 1'b1;
        free_way = NWAY_W'(w);
      end
    end
    // oldest rank wins, lowest way on a tie
    for (int w = 1; w < NEAR_WAYS; w++) begin
      if (row_i[w].age > row_i[vic_way].age) begin
        vic_way = NWAY_W'(w);
      end
    end

    priority if (hit) begin
      sel = hit_way;
    end else if (has_free) begin
      sel = free_way;
    end else begin
      sel = vic_way;
    end
    was_valid = hit || !has_free;
    old_age   = row_i[sel].age;

    row_o = row_i;
    for (int k = 0; k < NEAR_WAYS; k++) begin
      if (NWAY_W'(k) != sel && row_i[k].valid && (!was_valid || row_i[k].age < old_age)) begin
        row_o[k].age = row_i[k].age + 1'b1;
      end
    end
    row_o[sel].age = '0;
    if (!hit) begin
      row_o[sel].tag   = tag_i;
      row_o[sel].valid = 1'b1;
    end

    stat_o.hit     = hit;
    stat_o.full    = !hit && !has_free;
    stat_o.vic_tag = row_i[vic_way].tag;
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for the exclusive L2/L3 tag cache
// Drives accesses through the start/busy handshake with random gaps. A
// transaction-level model of both tag stores predicts each access outcome
// and L2 victim; directed rows use their own expected words. Every done_o
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import extlc_pkg::*;

  localparam int N_RANDOM = 1130;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               vvalid;
    logic [BLOCK_W-1:0] vblock;
    logic               vdrop;
  } access_res_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit                typed;
    access_res_t       res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [ADDR_W-1:0]  access_address_i;
  logic               done_o;
  logic [1:0]         outcome_o;
  logic               victim_valid_o;
  logic [BLOCK_W-1:0] victim_block_o;
  logic               victim_dropped_o;

  exclusive_two_level_cache i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .access_address_i (access_address_i),
    .done_o           (done_o),
    .outcome_o        (outcome_o),
    .victim_valid_o   (victim_valid_o),
    .victim_block_o   (victim_block_o),
    .victim_dropped_o (victim_dropped_o)
  );

  // Shadow copy of both tag stores
  logic [NTAG_W-1:0] l2_tag  [NEAR_SETS*NEAR_WAYS];
  bit                l2_vld  [NEAR_SETS*NEAR_WAYS];
  int unsigned       l2_rank [NEAR_SETS*NEAR_WAYS];
  logic [FTAG_W-1:0] l3_tag  [FAR_SETS*FAR_WAYS];
  bit                l3_vld  [FAR_SETS*FAR_WAYS];

  access_res_t pending_q[$];
  int          n_fail;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // Make way w the most recent line of its set
  function automatic void l2_promote(int base, int w, bit was_valid);
    int unsigned old_rank;
    old_rank = l2_rank[base+w];
    for (int k = 0; k < NEAR_WAYS; k++) begin
      if (k != w && l2_vld[base+k] && (!was_valid || l2_rank[base+k] < old_rank))
        l2_rank[base+k]++;
    end
    l2_rank[base+w] = 0;
  endfunction

  function automatic access_res_t cache_access(logic [ADDR_W-1:0] addr);
    access_res_t       r;
    logic [BLOCK_W-1:0] blk, vb;
    logic [NSET_W-1:0]  nset;
    logic [NTAG_W-1:0]  ntag;
    int                 nbase, fbase, vbase, far_hit, vic, free_w;
    logic [FTAG_W-1:0]  ftag;
    blk     = addr[ADDR_W-1:OFFSET_BITS];
    nset    = blk[NSET_W-1:0];
    ntag    = blk[BLOCK_W-1:NSET_W];
    nbase   = int'(nset) * NEAR_WAYS;
    fbase   = int'(blk[FSET_W-1:0]) * FAR_WAYS;
    ftag    = blk[BLOCK_W-1:FSET_W];
    r       = '0;
    r.outcome = OUT_MISS;
    far_hit = -1;
    for (int w = 0; w < NEAR_WAYS; w++) begin
      if (l2_vld[nbase+w] && l2_tag[nbase+w] == ntag) begin
        l2_promote(nbase, w, 1'b1);
        r.outcome = OUT_L2_HIT;
        return r;
      end
    end
    for (int w = FAR_WAYS - 1; w >= 0; w--)
      if (l3_vld[fbase+w] && l3_tag[fbase+w] == ftag) far_hit = w;
    free_w = -1;
    for (int w = NEAR_WAYS - 1; w >= 0; w--)
      if (!l2_vld[nbase+w]) free_w = w;
    if (free_w >= 0) begin
      l2_tag[nbase+free_w] = ntag;
      l2_vld[nbase+free_w] = 1'b1;
      l2_promote(nbase, free_w, 1'b0);
    end else begin
      vic = 0;
      for (int w = 1; w < NEAR_WAYS; w++)
        if (l2_rank[nbase+w] > l2_rank[nbase+vic]) vic = w;
      vb       = {l2_tag[nbase+vic], nset};
      vbase    = int'(vb[FSET_W-1:0]) * FAR_WAYS;
      r.vvalid = 1'b1;
      r.vblock = vb;
      r.vdrop  = 1'b1;
      // victim goes to L3 before the hit way is freed
      for (int f = 0; f < FAR_WAYS; f++) begin
        if (!l3_vld[vbase+f]) begin
          l3_vld[vbase+f] = 1'b1;
          l3_tag[vbase+f] = vb[BLOCK_W-1:FSET_W];
          r.vdrop = 1'b0;
          break;
        end
      end
      l2_tag[nbase+vic] = ntag;
      l2_promote(nbase, vic, 1'b1);
    end
    if (far_hit >= 0) begin
      l3_vld[fbase+far_hit] = 1'b0;
      r.outcome = OUT_L3_HIT;
    end
    return r;
  endfunction

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    access_res_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result word with no access pending");
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (outcome_o !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, outcome_o);
          n_fail++;
        end
        if (victim_valid_o !== want.vvalid) begin
          $error("victim_valid: expected %0d, got %0d", want.vvalid, victim_valid_o);
          n_fail++;
        end
        if (victim_block_o !== want.vblock) begin
          $error("victim_block: expected %h, got %h", want.vblock, victim_block_o);
          n_fail++;
        end
        if (victim_dropped_o !== want.vdrop) begin
          $error("victim_dropped: expected %0d, got %0d", want.vdrop, victim_dropped_o);
          n_fail++;
        end
      end
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Hold start high until the word is taken, then record its prediction
  task automatic issue(logic [ADDR_W-1:0] addr, bit typed, access_res_t typed_res);
    access_res_t p;
    int          gap;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    access_address_i <= addr;
    do @(posedge clk_i); while (busy);
    p = cache_access(addr);
    pending_q.push_back(typed ? typed_res : p);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr(logic [NSET_W-1:0] hot[4]);
    logic [NTAG_W-1:0] tag;
    logic [NSET_W-1:0] nset;
    int                sel;
    sel  = $urandom_range(0, 99);
    nset = hot[$urandom_range(0, 3)];
    tag  = NTAG_W'($urandom_range(0, 39));
    if (sel < 10) return {$urandom, $urandom};
    if (sel < 20) tag[NTAG_W-1 -: 16] = 16'($urandom);
    return {tag, nset, 6'($urandom)};
  endfunction

  initial begin
    stim_row_t         rows[$];
    logic [NSET_W-1:0] hot[4];
    access_res_t       none;
    none                = '0;
    n_fail              = 0;
    rst_ni              = 1'b0;
    start               = 1'b0;
    access_address_i    = '0;

    // Fill set 0 with tags 0..7, then evict and recall from L3
    rows.push_back('{64'h0, 1'b1, '{OUT_MISS, 1'b0, '0, 1'b0}});
    rows.push_back('{64'h3f, 1'b1, '{OUT_L2_HIT, 1'b0, '0, 1'b0}});
    for (int t = 1; t < 8; t++)
      rows.push_back('{ADDR_W'(t) << 16, 1'b1, '{OUT_MISS, 1'b0, '0, 1'b0}});
    rows.push_back('{64'h8_0000, 1'b1, '{OUT_MISS, 1'b1, '0, 1'b0}});
    rows.push_back('{64'h0, 1'b1, '{OUT_L3_HIT, 1'b1, BLOCK_W'(1024), 1'b0}});
    rows.push_back('{'1, 1'b1, '{OUT_MISS, 1'b0, '0, 1'b0}});
    rows.push_back('{'1, 1'b1, '{OUT_L2_HIT, 1'b0, '0, 1'b0}});
    rows.push_back('{64'h8000_0000_0000_0000, 1'b0, none});
    rows.push_back('{64'h5555_5555_5555_5555, 1'b0, none});
    rows.push_back('{64'haaaa_aaaa_aaaa_aaaa, 1'b0, none});
    // same near set, same far set: drive L3 set 2047 toward full
    for (int t = 0; t < 10; t++)
      rows.push_back('{{NTAG_W'(2*t + 1), NSET_W'(1023), 6'h0}, 1'b0, none});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) issue(rows[i].addr, rows[i].typed, rows[i].res);

    hot[0] = '0;
    hot[1] = '1;
    hot[2] = NSET_W'($urandom);
    hot[3] = NSET_W'($urandom);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // drain before going on
        start <= 1'b0;
        do @(posedge clk_i); while (pending_q.size() != 0);
      end
      issue(pick_addr(hot), 1'b0, none);
    end
    start <= 1'b0;

    fork
      begin
        while (pending_q.size() != 0) @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      begin
        repeat (5000) @(posedge clk_i);
        $error("results still pending at end of run");
        n_fail++;
      end
    join_any
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[exclusive_two_level_cache.f]
hdl/extlc_pkg.sv
hdl/extlc_near_ram.sv
hdl/extlc_far_ram.sv
hdl/extlc_near_upd.sv
hdl/exclusive_two_level_cache.sv
test/tb.sv
